// ----- hdl/sawb_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sawb_pkg: shared types and constants for the cache tag core
// Address geometry, beat payload structs and the lookup status bundle.
// ----------------------------------------------------------------------------
package sawb_pkg;

	localparam int unsigned ADDR_W       = 32;
	localparam int unsigned NUM_SETS     = 128;
	localparam int unsigned LINE_BYTES   = 64;
	localparam int unsigned DEF_NUM_WAYS = 4;
	localparam int unsigned OFFSET_W     = $clog2(LINE_BYTES);
	localparam int unsigned SET_W        = $clog2(NUM_SETS);
	localparam int unsigned TAG_W        = ADDR_W - OFFSET_W - SET_W;

	typedef struct packed {
		logic [ADDR_W-1:0] address;
		logic              is_write;
	} req_t;

	typedef struct packed {
		logic              hit;
		logic              writeback_valid;
		logic [ADDR_W-1:0] writeback_addr;
		logic              fill_valid;
		logic [ADDR_W-1:0] fill_addr;
		logic [31:0]       hit_count;
		logic [31:0]       miss_count;
	} rsp_t;

	// Outcome of one set lookup.
	typedef struct packed {
		logic             hit;
		logic             wb_valid;
		logic [TAG_W-1:0] wb_tag;
	} lookup_stat_t;

endpackage

// ----- hdl/sawb_tag_store.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sawb_tag_store: per-set tag, state and LRU rank storage
// One row per set, read with registered data, written back in the cycle after the read,
// with a forward path for back-to-back accesses to the same set.
// ----------------------------------------------------------------------------
module sawb_tag_store #(
	parameter int unsigned NUM_WAYS = sawb_pkg::DEF_NUM_WAYS,
	parameter int unsigned RANK_W   = 2
) (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  logic                                   rd_en,
	input  logic [sawb_pkg::SET_W-1:0]             rd_set,
	input  logic                                   wr_en,
	input  logic [sawb_pkg::SET_W-1:0]             wr_set,
	input  logic [NUM_WAYS-1:0]                    wr_valid,
	input  logic [NUM_WAYS-1:0]                    wr_dirty,
	input  logic [NUM_WAYS-1:0][RANK_W-1:0]        wr_rank,
	input  logic [NUM_WAYS-1:0][sawb_pkg::TAG_W-1:0] wr_tag,
	output logic [NUM_WAYS-1:0]                    rd_valid,
	output logic [NUM_WAYS-1:0]                    rd_dirty,
	output logic [NUM_WAYS-1:0][RANK_W-1:0]        rd_rank,
	output logic [NUM_WAYS-1:0][sawb_pkg::TAG_W-1:0] rd_tag
);
	import sawb_pkg::*;

	localparam int unsigned ROW_W = NUM_WAYS * (2 + RANK_W + TAG_W);

	logic [ROW_W-1:0]    mem [NUM_SETS];
	logic [ROW_W-1:0]    wr_row;
	logic [ROW_W-1:0]    rd_q;
	logic [ROW_W-1:0]    fwd_row_q;
	logic [ROW_W-1:0]    reset_row;
	logic [ROW_W-1:0]    row_sel;
	logic [NUM_SETS-1:0] row_valid_q;
	logic                rv_q;
	logic                fwd_sel_q;
	logic [NUM_WAYS-1:0][RANK_W-1:0] init_rank;

	assign wr_row = {wr_valid, wr_dirty, wr_rank, wr_tag};

	// A set that was never written reads as the reset state: all ways
	// empty and clean, ranked by way number.
	always_comb begin
		for (int w = 0; w < NUM_WAYS; w++) begin
			init_rank[w] = RANK_W'(w);
		end
	end
	assign reset_row = {{NUM_WAYS{1'b0}}, {NUM_WAYS{1'b0}}, init_rank,
		{(NUM_WAYS * TAG_W){1'b0}}};

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_set] <= wr_row;
		end
		if (rd_en) begin
			rd_q      <= mem[rd_set];
			fwd_row_q <= wr_row;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_valid_q <= '0;
			rv_q        <= 1'b0;
			fwd_sel_q   <= 1'b0;
		end else begin
			if (wr_en) begin
				row_valid_q[wr_set] <= 1'b1;
			end
			if (rd_en) begin
				rv_q      <= row_valid_q[rd_set];
				fwd_sel_q <= wr_en && (wr_set == rd_set);
			end
		end
	end

	assign row_sel = fwd_sel_q ? fwd_row_q : (rv_q ? rd_q : reset_row);
	assign {rd_valid, rd_dirty, rd_rank, rd_tag} = row_sel;

endmodule

// ----- hdl/sawb_lookup.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sawb_lookup: tag compare, victim choice and LRU rank update for one set
// Pure combinational logic over the row of one set.
// ----------------------------------------------------------------------------
module sawb_lookup #(
	parameter int unsigned NUM_WAYS = sawb_pkg::DEF_NUM_WAYS,
	parameter int unsigned RANK_W   = 2
) (
	input  logic [sawb_pkg::TAG_W-1:0]               tag_in,
	input  logic                                     is_write,
	input  logic [NUM_WAYS-1:0]                      cur_valid,
	input  logic [NUM_WAYS-1:0]                      cur_dirty,
	input  logic [NUM_WAYS-1:0][RANK_W-1:0]          cur_rank,
	input  logic [NUM_WAYS-1:0][sawb_pkg::TAG_W-1:0] cur_tag,
	output sawb_pkg::lookup_stat_t                   stat,
	output logic [NUM_WAYS-1:0]                      new_valid,
	output logic [NUM_WAYS-1:0]                      new_dirty,
	output logic [NUM_WAYS-1:0][RANK_W-1:0]          new_rank,
	output logic [NUM_WAYS-1:0][sawb_pkg::TAG_W-1:0] new_tag
);
	import sawb_pkg::*;

	localparam logic [RANK_W-1:0] TOP_RANK = RANK_W'(NUM_WAYS - 1);

	logic              hit_found;
	logic              vic_found;
	logic [RANK_W-1:0] hit_way;
	logic [RANK_W-1:0] vic_way;
	logic [RANK_W-1:0] touch_way;
	logic [RANK_W-1:0] old_rank;

	always_comb begin
		hit_found = 1'b0;
		hit_way   = '0;
		vic_found = 1'b0;
		vic_way   = '0;
		for (int w = 0; w < NUM_WAYS; w++) begin
			if (!hit_found && cur_valid[w] && (cur_tag[w] == tag_in)) begin
				hit_found = 1'b1;
				hit_way   = RANK_W'(w);
			end
			if (!vic_found && (cur_rank[w] == '0)) begin
				vic_found = 1'b1;
				vic_way   = RANK_W'(w);
			end
		end
	end

	assign touch_way = hit_found ? hit_way : vic_way;
	assign old_rank  = cur_rank[touch_way];

	always_comb begin
		stat.hit      = hit_found;
		stat.wb_valid = !hit_found && cur_valid[vic_way] && cur_dirty[vic_way];
		stat.wb_tag   = cur_tag[vic_way];
		new_valid     = cur_valid;
		new_dirty     = cur_dirty;
		new_tag       = cur_tag;
		for (int w = 0; w < NUM_WAYS; w++) begin
			if (cur_rank[w] > old_rank) begin
				new_rank[w] = cur_rank[w] - 1'b1;
			end else begin
				new_rank[w] = cur_rank[w];
			end
		end
		new_rank[touch_way] = TOP_RANK;
		if (hit_found) begin
			if (is_write) begin
				new_dirty[touch_way] = 1'b1;
			end
		end else begin
			new_valid[touch_way] = 1'b1;
			new_dirty[touch_way] = is_write;
			new_tag[touch_way]   = tag_in;
		end
	end

endmodule

// ----- hdl/set_assoc_lru_writeback_cache_tags_core.sv -----
`timescale 1ns / 1ps
// A result reaches the result ports once its beat has passed stage 1 and the result register.
// Throughput: one access per cycle; busy never rises, so back-to-back beats are taken.
// The set's row is read from the tag memory in the accept cycle and written back
// in the next; a same-set follow-up access takes the new row from a forward path.
// Reset clears the per-set valid bits, the counters and the strobe; the
// tag memory itself is never swept, a set that was never written reads as empty.
// ----------------------------------------------------------------------------
// set_assoc_lru_writeback_cache_tags_core: tag and LRU logic of a cache
// Set-associative, write-allocate, write-back tag lookup with true LRU ranks,
// writeback and fill reporting, and running hit and miss counters.
// ----------------------------------------------------------------------------
module set_assoc_lru_writeback_cache_tags_core #(
	parameter int unsigned NUM_WAYS = sawb_pkg::DEF_NUM_WAYS
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           start,
	output logic           busy,
	input  sawb_pkg::req_t req,
	output logic           done,
	output sawb_pkg::rsp_t result
);
	import sawb_pkg::*;

	// Rank width: a one-way cache still keeps a single rank bit.
	localparam int unsigned RANK_W = (NUM_WAYS > 1) ? $clog2(NUM_WAYS) : 1;

	logic             accept;
	logic [SET_W-1:0] set_in;

	// Stage 1 holds the accepted beat while its set row comes out of memory.
	logic             v_s1;
	req_t             req_s1;
	logic [SET_W-1:0] set_s1;
	logic [TAG_W-1:0] tag_s1;

	logic [NUM_WAYS-1:0]             cur_valid, new_valid;
	logic [NUM_WAYS-1:0]             cur_dirty, new_dirty;
	logic [NUM_WAYS-1:0][RANK_W-1:0] cur_rank, new_rank;
	logic [NUM_WAYS-1:0][TAG_W-1:0]  cur_tag, new_tag;
	lookup_stat_t                    stat;

	rsp_t        rsp_d;
	rsp_t        result_q;
	logic        done_q;
	logic [31:0] hits_q;
	logic [31:0] misses_q;

	// The lookup never waits on anything, so the core is always ready.
	assign busy   = 1'b0;
	assign accept = start && !busy;
	assign set_in = req.address[OFFSET_W +: SET_W];
	assign set_s1 = req_s1.address[OFFSET_W +: SET_W];
	assign tag_s1 = req_s1.address[ADDR_W-1 -: TAG_W];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else begin
			v_s1 <= accept;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			req_s1 <= req;
		end
	end

	sawb_tag_store #(
		.NUM_WAYS (NUM_WAYS),
		.RANK_W   (RANK_W)
	) u_store (
		.clk      (clk),
		.arst_n   (arst_n),
		.rd_en    (accept),
		.rd_set   (set_in),
		.wr_en    (v_s1),
		.wr_set   (set_s1),
		.wr_valid (new_valid),
		.wr_dirty (new_dirty),
		.wr_rank  (new_rank),
		.wr_tag   (new_tag),
		.rd_valid (cur_valid),
		.rd_dirty (cur_dirty),
		.rd_rank  (cur_rank),
		.rd_tag   (cur_tag)
	);

	sawb_lookup #(
		.NUM_WAYS (NUM_WAYS),
		.RANK_W   (RANK_W)
	) u_lookup (
		.tag_in    (tag_s1),
		.is_write  (req_s1.is_write),
		.cur_valid (cur_valid),
		.cur_dirty (cur_dirty),
		.cur_rank  (cur_rank),
		.cur_tag   (cur_tag),
		.stat      (stat),
		.new_valid (new_valid),
		.new_dirty (new_dirty),
		.new_rank  (new_rank),
		.new_tag   (new_tag)
	);

	// Build the result beat. The writeback address is the victim's block
	// address: its old tag, this set, and a zero line offset.
	always_comb begin
		rsp_d.hit             = stat.hit;
		rsp_d.writeback_valid = stat.wb_valid;
		rsp_d.writeback_addr  = stat.wb_valid ?
			{stat.wb_tag, set_s1, {OFFSET_W{1'b0}}} : '0;
		rsp_d.fill_valid      = !stat.hit;
		rsp_d.fill_addr       = stat.hit ? '0 : req_s1.address;
		rsp_d.hit_count       = hits_q + 32'(stat.hit);
		rsp_d.miss_count      = misses_q + 32'(!stat.hit);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q   <= 1'b0;
			hits_q   <= '0;
			misses_q <= '0;
		end else begin
			done_q <= v_s1;
			if (v_s1) begin
				hits_q   <= rsp_d.hit_count;
				misses_q <= rsp_d.miss_count;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (v_s1) begin
			result_q <= rsp_d;
		end
	end

	assign done   = done_q;
	assign result = result_q;

`ifndef ASSERT_OFF
	// Every accepted beat produces a result strobe once it has passed stage 1 and the result register.
	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> ##1 done)
		else $error("result strobe missing two cycles after accept");

	// An access is either a hit or a fill, never both or neither.
	a_hit_or_fill: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> (result.hit != result.fill_valid))
		else $error("hit and fill_valid disagree");

	// A writeback only accompanies a miss.
	a_wb_on_miss: assert property (@(posedge clk) disable iff (!arst_n)
		done && result.writeback_valid |-> result.fill_valid && !result.hit)
		else $error("writeback reported without a miss");

	// Back-to-back results advance the combined access count by one.
	a_count_step: assert property (@(posedge clk) disable iff (!arst_n)
		done && $past(done) |->
			(result.hit_count + result.miss_count) ==
			($past(result.hit_count) + $past(result.miss_count) + 32'd1))
		else $error("hit and miss counters out of step");
`endif

endmodule
